// File: rtl/ckx_pkg.sv
package ckx_pkg;

  localparam int unsigned MaxK    = 32;
  localparam int unsigned BaseW   = 2;
  localparam int unsigned KeyW    = 2 * MaxK;
  localparam int unsigned CntW    = $clog2(MaxK + 1);
  localparam int unsigned IdxW    = (MaxK > 1) ? $clog2(MaxK) : 1;
  localparam int unsigned KLenW   = 6;
  localparam int unsigned PAddrW  = 3;
  localparam int unsigned PDataW  = 32;

  // Register word index, taken from paddr[PAddrW-1:2]
  localparam logic [PAddrW-3:0] RegKmerLength = '0;

  localparam logic [KLenW-1:0] KmerLengthReset = KLenW'(21);

  typedef struct packed {
    logic [1:0] base;
    logic       is_base;
    logic       new_read;
  } in_item_t;

  typedef struct packed {
    logic [KeyW-1:0] canonical_key;
    logic            from_forward;
  } out_item_t;

  // Broadcast control from the top level to every cell
  typedef struct packed {
    logic             load;   // an item is taken this cycle
    logic             flush;  // non-base: zero the whole row
    logic             clear;  // new read: drop old contents before the shift
    logic [BaseW-1:0] base;
    logic [IdxW-1:0]  km1;    // effective k minus one
  } cell_ctrl_t;

endpackage

// File: rtl/ckx_cell.sv
module ckx_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [ckx_pkg::IdxW-1:0]  idx_i,
  input  ckx_pkg::cell_ctrl_t     ctrl_i,
  input  logic [ckx_pkg::BaseW-1:0] fwd_i,   // from the cell one position lower
  input  logic [ckx_pkg::BaseW-1:0] rev_i,   // masked, from the cell one position higher
  output logic [ckx_pkg::BaseW-1:0] fwd_o,
  output logic [ckx_pkg::BaseW-1:0] rev_o,   // stored reverse digit, masked to k
  output logic [ckx_pkg::BaseW-1:0] fwd_d_o,
  output logic [ckx_pkg::BaseW-1:0] rev_d_o
);

  logic [ckx_pkg::BaseW-1:0] fwd_q, fwd_d;
  logic [ckx_pkg::BaseW-1:0] rev_q, rev_d;
  logic                      active;
  logic [ckx_pkg::BaseW-1:0] src_fwd, src_rev;

  assign active  = (idx_i <= ctrl_i.km1);
  assign src_fwd = ctrl_i.clear ? '0 : fwd_i;
  assign src_rev = ctrl_i.clear ? '0 : rev_i;

  always_comb begin
    fwd_d = fwd_q;
    rev_d = rev_q;
    if (ctrl_i.load) begin
      if (ctrl_i.flush || !active) begin
        fwd_d = '0;
        rev_d = '0;
      end else begin
        // forward key shifts toward higher positions, new base at the bottom
        fwd_d = (idx_i == '0) ? ctrl_i.base : src_fwd;
        // reverse key shifts down, complement enters at the top position
        rev_d = (idx_i == ctrl_i.km1) ? ~ctrl_i.base : src_rev;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= '0;
      rev_q <= '0;
    end else begin
      fwd_q <= fwd_d;
      rev_q <= rev_d;
    end
  end

  assign fwd_o   = fwd_q;
  assign rev_o   = active ? rev_q : '0;
  assign fwd_d_o = fwd_d;
  assign rev_d_o = rev_d;

endmodule

// File: rtl/canonical_kmer_extractor.sv
// Canonical k-mer extractor.
// Input channel: one base item per accepted handshake (base code, is_base,
// new_read). Output channel: one canonical k-mer item (2k-bit key, strand
// flag) for every valid base once k valid bases have been taken in a row.
// Non-base items and items before the row is full give no output item.
// Configuration: APB-style port, register 0 (byte address 0) holds
// kmer_length; 0 acts as 1 and values above 32 act as 32. Write it only
// while the block is idle.
// Throughput: one item per cycle while in_ready_o is high. The row of 32
// base cells shifts and the 64-bit compare feeding the output register sits
// in the same cycle, so the rate is bound by that shift-compare path.
// Output: a result item shows on the output in the cycle after its base item
// is accepted.
// Reset: both keys, the fill count and the output valid flag clear; the
// length register returns to 21.
// Stall: the output register holds its item while out_ready_i is low; the
// input keeps flowing while the output register is free or being drained
// in the same cycle, otherwise in_ready_o drops.
module canonical_kmer_extractor (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // base items
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  ckx_pkg::in_item_t                in_item_i,
  // k-mer items
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output ckx_pkg::out_item_t               out_item_o,
  // configuration
  input  logic                             psel_i,
  input  logic                             penable_i,
  input  logic                             pwrite_i,
  input  logic [ckx_pkg::PAddrW-1:0]       paddr_i,
  input  logic [ckx_pkg::PDataW-1:0]       pwdata_i,
  output logic [ckx_pkg::PDataW-1:0]       prdata_o,
  output logic                             pready_o
);

  localparam int unsigned MaxK  = ckx_pkg::MaxK;
  localparam int unsigned BaseW = ckx_pkg::BaseW;
  localparam int unsigned IdxW  = ckx_pkg::IdxW;
  localparam int unsigned CntW  = ckx_pkg::CntW;
  localparam int unsigned KLenW = ckx_pkg::KLenW;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [KLenW-1:0] kmer_length_q, kmer_length_d;
  logic             reg_sel;
  logic             cfg_write;

  assign pready_o  = 1'b1;
  assign reg_sel   = (paddr_i[ckx_pkg::PAddrW-1:2] == ckx_pkg::RegKmerLength);
  assign cfg_write = psel_i && penable_i && pwrite_i && pready_o;

  always_comb begin
    kmer_length_d = kmer_length_q;
    if (cfg_write && reg_sel) begin
      kmer_length_d = pwdata_i[KLenW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_length_q <= ckx_pkg::KmerLengthReset;
    end else begin
      kmer_length_q <= kmer_length_d;
    end
  end

  assign prdata_o = reg_sel ? {{(ckx_pkg::PDataW - KLenW){1'b0}}, kmer_length_q} : '0;

  // Effective k minus one: clamp 0 up to 1 and anything above MaxK down to MaxK
  logic [IdxW-1:0] km1;
  logic [KLenW-1:0] k_eff;

  always_comb begin
    if (kmer_length_q == '0) begin
      k_eff = KLenW'(1);
    end else if (kmer_length_q > KLenW'(MaxK)) begin
      k_eff = KLenW'(MaxK);
    end else begin
      k_eff = kmer_length_q;
    end
  end

  assign km1 = IdxW'(k_eff - KLenW'(1));

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  logic in_fire;
  logic out_valid_q, out_valid_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // Fill count: valid bases since the last clear, saturating at MaxK
  // ---------------------------------------------------------------------------
  logic [CntW-1:0] fill_q, fill_d;
  logic [CntW-1:0] fill_base;
  logic [CntW-1:0] fill_inc;
  logic            emit;

  assign fill_base = in_item_i.new_read ? '0 : fill_q;
  assign fill_inc  = (fill_base == CntW'(MaxK)) ? fill_base : fill_base + CntW'(1);
  assign emit      = in_fire && in_item_i.is_base && (fill_inc >= CntW'(k_eff));

  always_comb begin
    fill_d = fill_q;
    if (in_fire) begin
      fill_d = in_item_i.is_base ? fill_inc : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Row of base cells
  // ---------------------------------------------------------------------------
  ckx_pkg::cell_ctrl_t ctrl;

  assign ctrl.load  = in_fire;
  assign ctrl.flush = !in_item_i.is_base;
  assign ctrl.clear = in_item_i.new_read;
  assign ctrl.base  = in_item_i.base;
  assign ctrl.km1   = km1;

  logic [BaseW-1:0] fwd_q_c [MaxK];
  logic [BaseW-1:0] rev_q_c [MaxK];
  logic [BaseW-1:0] fwd_d_c [MaxK];
  logic [BaseW-1:0] rev_d_c [MaxK];
  logic [ckx_pkg::KeyW-1:0] fwd_next, rev_next;

  for (genvar i = 0; i < MaxK; i++) begin : g_cell
    logic [BaseW-1:0] fwd_in, rev_in;

    if (i == 0) begin : g_lo
      assign fwd_in = '0;
    end else begin : g_mid_lo
      assign fwd_in = fwd_q_c[i-1];
    end

    if (i == MaxK - 1) begin : g_hi
      assign rev_in = '0;
    end else begin : g_mid_hi
      assign rev_in = rev_q_c[i+1];
    end

    ckx_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (IdxW'(i)),
      .ctrl_i  (ctrl),
      .fwd_i   (fwd_in),
      .rev_i   (rev_in),
      .fwd_o   (fwd_q_c[i]),
      .rev_o   (rev_q_c[i]),
      .fwd_d_o (fwd_d_c[i]),
      .rev_d_o (rev_d_c[i])
    );

    assign fwd_next[BaseW*i +: BaseW] = fwd_d_c[i];
    assign rev_next[BaseW*i +: BaseW] = rev_d_c[i];
  end

  // ---------------------------------------------------------------------------
  // Output register: pick the smaller key of the updated row
  // ---------------------------------------------------------------------------
  ckx_pkg::out_item_t out_q, out_d;
  logic               fwd_lt;

  assign fwd_lt = (fwd_next < rev_next);

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (emit) begin
      out_valid_d         = 1'b1;
      out_d.canonical_key = fwd_lt ? fwd_next : rev_next;
      out_d.from_forward  = fwd_lt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: dv/kmer_checker.sv
module kmer_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  ckx_pkg::in_item_t            in_item_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  ckx_pkg::out_item_t           out_item_i,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [ckx_pkg::PAddrW-1:0]   paddr_i,
  input  logic [ckx_pkg::PDataW-1:0]   pwdata_i,
  input  logic [ckx_pkg::PDataW-1:0]   prdata_i,
  input  logic                         pready_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [ckx_pkg::KLenW-1:0] kmer_len_q;
  logic [ckx_pkg::KeyW-1:0]  fwd_key_q;
  logic [ckx_pkg::KeyW-1:0]  rc_key_q;
  logic [ckx_pkg::KLenW-1:0] run_len_q;
  ckx_pkg::out_item_t        kmer_expected_q[$];

  // 0 acts as 1, anything above the row size acts as the row size
  function automatic int unsigned kmer_span(logic [ckx_pkg::KLenW-1:0] len);
    if (len == '0) return 1;
    if (len > ckx_pkg::MaxK) return ckx_pkg::MaxK;
    return len;
  endfunction

  // Shift one base into both keys; return 1 when a canonical k-mer comes out
  function automatic bit roll_base(input ckx_pkg::in_item_t it,
                                   output ckx_pkg::out_item_t kmer);
    int unsigned              k;
    logic [ckx_pkg::KeyW-1:0] m;
    kmer = '0;
    k = kmer_span(kmer_len_q);
    m = (k >= 32) ? '1 : ((64'd1 << (2 * k)) - 64'd1);
    if (it.new_read || !it.is_base) begin
      fwd_key_q = '0;
      rc_key_q  = '0;
      run_len_q = '0;
    end
    if (!it.is_base) return 1'b0;
    fwd_key_q = ((fwd_key_q << 2) | 64'(it.base)) & m;
    rc_key_q  = ((rc_key_q & m) >> 2) | (64'(2'd3 - it.base) << (2 * k - 2));
    rc_key_q  = rc_key_q & m;
    if (run_len_q < ckx_pkg::MaxK) run_len_q = run_len_q + 1'b1;
    if (run_len_q < k) return 1'b0;
    if (fwd_key_q < rc_key_q) begin
      kmer.canonical_key = fwd_key_q;
      kmer.from_forward  = 1'b1;
    end else begin
      kmer.canonical_key = rc_key_q;
      kmer.from_forward  = 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_len_q   = ckx_pkg::KmerLengthReset;
      fwd_key_q    = '0;
      rc_key_q     = '0;
      run_len_q    = '0;
      kmer_expected_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      ckx_pkg::out_item_t want;
      ckx_pkg::out_item_t kmer;
      // compare first: a result never leaves in the cycle its base arrives
      if (out_valid_i && out_ready_i) begin
        if (kmer_expected_q.size() == 0) begin
          $error("unexpected k-mer item: key %h strand %b",
                 out_item_i.canonical_key, out_item_i.from_forward);
          fail_count_o++;
        end else begin
          want = kmer_expected_q[0];
          kmer_expected_q.delete(0);
          if (out_item_i.canonical_key !== want.canonical_key) begin
            $error("canonical_key: expected %h, got %h",
                   want.canonical_key, out_item_i.canonical_key);
            fail_count_o++;
          end
          if (out_item_i.from_forward !== want.from_forward) begin
            $error("from_forward: expected %b, got %b",
                   want.from_forward, out_item_i.from_forward);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (roll_base(in_item_i, kmer)) kmer_expected_q.insert(kmer_expected_q.size(), kmer);
      end
      if (psel_i && penable_i && pready_i
          && paddr_i[ckx_pkg::PAddrW-1:2] == ckx_pkg::RegKmerLength) begin
        if (pwrite_i) begin
          kmer_len_q = pwdata_i[ckx_pkg::KLenW-1:0];
        end else if (prdata_i[ckx_pkg::KLenW-1:0] !== kmer_len_q) begin
          $error("kmer_length: expected %0d, got %0d",
                 kmer_len_q, prdata_i[ckx_pkg::KLenW-1:0]);
          fail_count_o++;
        end
      end
      pending_o = kmer_expected_q.size();
    end
  end

endmodule

// File: dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ResetCycles   = 5;
  localparam int unsigned LongHold      = 400;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned PhaseItems    = 130;
  localparam int unsigned DrainCycles   = 4;

  // receiver stall patterns
  typedef enum logic [1:0] {
    RxOpen,
    RxMostly,
    RxSparse,
    RxToggle
  } rx_mode_e;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_ready_o;
  ckx_pkg::in_item_t            in_item_i   = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  ckx_pkg::out_item_t           out_item_o;
  logic                         psel_i      = 1'b0;
  logic                         penable_i   = 1'b0;
  logic                         pwrite_i    = 1'b0;
  logic [ckx_pkg::PAddrW-1:0]   paddr_i     = '0;
  logic [ckx_pkg::PDataW-1:0]   pwdata_i    = '0;
  logic [ckx_pkg::PDataW-1:0]   prdata_o;
  logic                         pready_o;

  int unsigned         fail_count;
  int unsigned         kmers_pending;
  int unsigned         bases_sent  = 0;
  int unsigned         burst_left  = 0;
  int unsigned         idle_cycles = 0;
  bit                  hold_req    = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  canonical_kmer_extractor dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_item_i,
    .out_valid_o,
    .out_ready_i,
    .out_item_o,
    .psel_i,
    .penable_i,
    .pwrite_i,
    .paddr_i,
    .pwdata_i,
    .prdata_o,
    .pready_o
  );

  kmer_checker kmer_check (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i   (in_ready_o),
    .in_item_i,
    .out_valid_i  (out_valid_o),
    .out_ready_i,
    .out_item_i   (out_item_o),
    .psel_i,
    .penable_i,
    .pwrite_i,
    .paddr_i,
    .pwdata_i,
    .prdata_i     (prdata_o),
    .pready_i     (pready_o),
    .fail_count_o (fail_count),
    .pending_o    (kmers_pending)
  );

  // Watchdog: end the run once nothing has moved on either channel for too long.
  // The long receiver hold-off stays well under the limit.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Receiver: switch between stall patterns at random, and honor one long
  // hold-off so the output register fills and the input backs up.
  initial begin
    rx_mode_e    mode;
    int unsigned left;
    mode = RxOpen;
    left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i = 1'b0;
        repeat (LongHold) @(negedge clk_i);
        hold_req = 1'b0;
      end
      if (left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        left = $urandom_range(16, 96);
      end
      left--;
      case (mode)
        RxOpen:   out_ready_i = 1'b1;
        RxMostly: out_ready_i = ($urandom_range(0, 3) != 0);
        RxSparse: out_ready_i = ($urandom_range(0, 3) == 0);
        default:  out_ready_i = ~out_ready_i;
      endcase
    end
  end

  function automatic ckx_pkg::in_item_t mk_base(logic [1:0] b, logic valid_base,
                                                logic fresh);
    ckx_pkg::in_item_t it;
    it.base     = b;
    it.is_base  = valid_base;
    it.new_read = fresh;
    return it;
  endfunction

  // Offer one item at the falling edge and hold it until it is taken. Between
  // bursts, drop valid for a random gap; inside a burst keep valid high.
  task automatic push_base(ckx_pkg::in_item_t it);
    in_item_i  = it;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bases_sent++;
    @(negedge clk_i);
    if (burst_left == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(0, 40);
    end else begin
      burst_left--;
    end
  endtask

  // Drop valid and wait until every expected k-mer has come out, then let the
  // pipeline drain any base item that produces nothing.
  task automatic settle();
    in_valid_i = 1'b0;
    while (kmers_pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Write kmer_length (with junk in the unused upper bits), then read it back.
  task automatic cfg_kmer_length(logic [ckx_pkg::KLenW-1:0] len);
    psel_i    = 1'b1;
    penable_i = 1'b0;
    pwrite_i  = 1'b1;
    paddr_i   = ckx_pkg::PAddrW'({ckx_pkg::RegKmerLength, 2'b00});
    pwdata_i  = $urandom();
    pwdata_i[ckx_pkg::KLenW-1:0] = len;
    @(negedge clk_i);
    penable_i = 1'b1;
    @(negedge clk_i);
    penable_i = 1'b0;
    pwrite_i  = 1'b0;
    @(negedge clk_i);
    penable_i = 1'b1;
    @(negedge clk_i);
    psel_i    = 1'b0;
    penable_i = 1'b0;
  endtask

  // A read: mostly proper bases, with a rare non-base to break the run
  task automatic send_read(bit fresh, int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      push_base(mk_base(2'($urandom_range(0, 3)), $urandom_range(0, 39) != 0,
                        fresh && (i == 0)));
    end
  endtask

  // Noise: random flags everywhere, including non-bases that also start a read
  task automatic send_noise(int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      push_base(mk_base(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                        $urandom_range(0, 3) == 0));
    end
  endtask

  // One setting of the length register, then reads of random length, often long
  // enough to fill the row. The first read may carry on from the previous phase
  // without a new-read flag, so a length change lands in the middle of a read.
  task automatic run_phase(logic [ckx_pkg::KLenW-1:0] len, bit long_hold);
    int unsigned span;
    int unsigned goal;
    int unsigned rlen;
    bit          first;
    settle();
    cfg_kmer_length(len);
    span  = (len == 0) ? 1 : ((len > ckx_pkg::MaxK) ? ckx_pkg::MaxK : len);
    goal  = bases_sent + PhaseItems;
    first = 1'b1;
    hold_req = long_hold;
    while (bases_sent < goal) begin
      rlen = $urandom_range(1, 2 * span + 8);
      // trim the last read so the phase sends exactly its share of items
      if (rlen > goal - bases_sent) rlen = goal - bases_sent;
      if ($urandom_range(0, 9) == 0) begin
        send_noise(rlen);
      end else begin
        send_read(first ? 1'($urandom_range(0, 1)) : 1'b1, rlen);
      end
      first = 1'b0;
    end
    in_valid_i = 1'b0;
  endtask

  initial begin
    logic [ckx_pkg::KLenW-1:0] sweep [8] = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd2, 6'd33,
                                             6'd31, 6'd5};

    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;
    burst_left = $urandom_range(0, 40);

    // Reset length 21: a run of T fills the row (forward all ones, reverse
    // complement all A, so the reverse strand wins), one more base, then a
    // non-base that also starts a read, and a plain non-base.
    push_base(mk_base(2'd3, 1'b1, 1'b1));
    repeat (20) push_base(mk_base(2'd3, 1'b1, 1'b0));
    push_base(mk_base(2'd1, 1'b1, 1'b0));
    push_base(mk_base(2'd2, 1'b0, 1'b1));
    push_base(mk_base(2'd1, 1'b0, 1'b0));
    push_base(mk_base(2'd0, 1'b1, 1'b0));

    // Length 2: AT and GC are their own reverse complements (tie), CA is
    // smaller than TG (forward strand wins).
    settle();
    cfg_kmer_length(6'd2);
    push_base(mk_base(2'd0, 1'b1, 1'b1));
    push_base(mk_base(2'd3, 1'b1, 1'b0));
    push_base(mk_base(2'd2, 1'b1, 1'b1));
    push_base(mk_base(2'd1, 1'b1, 1'b0));
    push_base(mk_base(2'd0, 1'b1, 1'b0));

    // Sweep the extremes and out-of-range lengths, then random lengths. The
    // first phase (length 1, a k-mer per base) carries the long hold-off.
    foreach (sweep[i]) run_phase(sweep[i], i == 0);
    repeat (4) run_phase(ckx_pkg::KLenW'($urandom_range(0, 63)), 1'b0);

    settle();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
